/* src/arht_pkg.sv */
// ----------------------------------------------------------------------------
// arht_pkg
// Shared types and codes for the address remap hash table.
// ----------------------------------------------------------------------------
package arht_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned KEY_W           = 64;
    localparam int unsigned DEFER_W         = 16;

    // operation codes
    localparam logic [1:0] OP_MAP     = 2'd0;
    localparam logic [1:0] OP_MAP_PTR = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MAPPED    = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // pointer action codes
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_TRANSLATE = 2'd1;
    localparam logic [1:0] ACT_NULL      = 2'd2;
    localparam logic [1:0] ACT_DEFER     = 2'd3;

    typedef logic [KEY_W-1:0]   t_addr;
    typedef logic [9:0]         t_eidx;
    typedef logic [10:0]        t_rcnt;
    typedef logic [DEFER_W-1:0] t_defer;

    typedef struct packed {
        logic [1:0]  op;
        t_addr       old_addr;
        t_addr       new_addr;
        t_addr       pointer_value;
        logic [31:0] pointer_kind;
        logic [31:0] item_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  pointer_action;
        t_addr       result_addr;
        t_eidx       entry_index;
        t_eidx       target_index;
        logic [31:0] fixup_kind;
        logic [31:0] fixup_size;
        t_rcnt       removed_count;
        t_defer      deferred_total;
    } t_rsp;

    localparam t_rcnt  RCNT_MAX  = '1;
    localparam t_defer DEFER_MAX = '1;

endpackage

/* src/arht_req_if.sv */
// ----------------------------------------------------------------------------
// arht_req_if
// Request channel: valid/ready handshake carrying one table operation.
// ----------------------------------------------------------------------------
interface arht_req_if;
    logic          valid;
    logic          ready;
    arht_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/arht_rsp_if.sv */
// ----------------------------------------------------------------------------
// arht_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface arht_rsp_if;
    logic          valid;
    logic          ready;
    arht_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/arht_ram.sv */
// ----------------------------------------------------------------------------
// arht_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module arht_ram #(
    parameter int unsigned DEPTH  = arht_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned DATA_W = arht_pkg::KEY_W,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/arht_hash.sv */
// ----------------------------------------------------------------------------
// arht_hash
// Home slot of a key: key mod TABLE_DEPTH. A power-of-two depth keeps the low
// key bits, registered; any other depth folds the key in four 16-bit digits,
// each digit by a reciprocal estimate, then one correcting subtract.
// ----------------------------------------------------------------------------
module arht_hash #(
    parameter int unsigned TABLE_DEPTH = arht_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned IW          = $clog2(TABLE_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  arht_pkg::t_addr      i_key,
    output logic                 o_done,
    output logic [IW-1:0]        o_rem
);

    generate
        if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) begin : g_mask
            logic          r_done;
            logic [IW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_rem <= i_key[IW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_digit
            localparam int unsigned DW = 16;
            localparam int unsigned XW = 2 * DW;
            localparam int unsigned PW = 2 * XW;
            localparam int unsigned ND = arht_pkg::KEY_W / DW;
            localparam int unsigned CW = $clog2(ND);
            localparam logic [XW-1:0] DEPTH_X  = XW'(TABLE_DEPTH);
            localparam logic [XW-1:0] RECIP    = XW'((64'd1 << XW) / TABLE_DEPTH);
            localparam logic [CW-1:0] LAST_DIG = CW'(ND - 1);

            logic            r_busy, n_busy;
            logic            r_done, n_done;
            logic            r_step, n_step;
            logic [CW-1:0]   r_cnt, n_cnt;
            arht_pkg::t_addr r_shift, n_shift;
            logic [IW-1:0]   r_rem, n_rem;
            logic [XW-1:0]   r_x, n_x;
            logic [XW-1:0]   r_q, n_q;
            logic [XW-1:0]   x_cat;
            logic [PW-1:0]   prod;
            logic [XW-1:0]   diff;

            always_comb begin
                n_busy  = r_busy;
                n_done  = 1'b0;
                n_step  = r_step;
                n_cnt   = r_cnt;
                n_shift = r_shift;
                n_rem   = r_rem;
                n_x     = r_x;
                n_q     = r_q;
                // remainder so far times 2^16 plus the next digit stays below 2^32
                x_cat   = {DW'(r_rem), r_shift[arht_pkg::KEY_W-1 -: DW]};
                prod    = {{XW{1'b0}}, x_cat} * {{XW{1'b0}}, RECIP};
                diff    = r_x - r_q * DEPTH_X;
                if (i_start) begin
                    n_busy  = 1'b1;
                    n_step  = 1'b0;
                    n_cnt   = '0;
                    n_shift = i_key;
                    n_rem   = '0;
                end else if (r_busy) begin
                    if (!r_step) begin
                        n_x    = x_cat;
                        n_q    = prod[PW-1:XW];
                        n_step = 1'b1;
                    end else begin
                        // quotient estimate is at most one low, one subtract finishes
                        if (diff >= DEPTH_X) begin
                            n_rem = IW'(diff - DEPTH_X);
                        end else begin
                            n_rem = IW'(diff);
                        end
                        n_shift = {r_shift[arht_pkg::KEY_W-DW-1:0], {DW{1'b0}}};
                        n_step  = 1'b0;
                        n_cnt   = r_cnt + 1'b1;
                        if (r_cnt == LAST_DIG) begin
                            n_busy = 1'b0;
                            n_done = 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_step <= 1'b0;
                end else begin
                    r_busy <= n_busy;
                    r_done <= n_done;
                    r_step <= n_step;
                end
                r_cnt   <= n_cnt;
                r_shift <= n_shift;
                r_rem   <= n_rem;
                r_x     <= n_x;
                r_q     <= n_q;
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

/* src/address_remap_hash_table.sv */
// ----------------------------------------------------------------------------
// address_remap_hash_table
// Open-addressed, linearly probed map from old to new addresses.
//
//   channel  dir  handshake      payload
//   i_req    in   valid/ready    op, old_addr, new_addr, pointer_value,
//                                pointer_kind, item_size
//   o_rsp    out  valid/ready    status, pointer_action, result_addr, ...
//
// After reset the key RAM is swept to zero, every entry in turn; no request
// is taken meanwhile. One request is worked at a time: map and lookup probe
// entries from the home slot, one per cycle through the key RAM read port;
// the home slot is found by a digit-wise fold when TABLE_DEPTH is not a
// power of two. Map pointer adds a second hash and probe. Remove scans every
// entry. A finished result waits in the output register while the next
// request is taken.
// ----------------------------------------------------------------------------
module address_remap_hash_table #(
    parameter int unsigned TABLE_DEPTH = arht_pkg::TABLE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    arht_req_if.sink        i_req,
    arht_rsp_if.source      o_rsp
);

    localparam int unsigned   IW   = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_HASH   = 6'b000100,
        S_PROBE  = 6'b001000,
        S_REMOVE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic             r_phase, n_phase;
    arht_pkg::t_req   r_item, n_item;
    arht_pkg::t_rsp   r_res, n_res;
    arht_pkg::t_rsp   r_out, n_out;
    logic             r_out_valid, n_out_valid;
    arht_pkg::t_defer r_defer, n_defer;

    logic             h_start, h_done;
    arht_pkg::t_addr  h_key;
    logic [IW-1:0]    h_rem;

    logic             k_we, v_we;
    arht_pkg::t_addr  k_wdata, k_rdata, v_rdata;
    arht_pkg::t_addr  probe_key;
    logic             hit, empty;

    arht_hash #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW)) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_key   (h_key),
        .o_done  (h_done),
        .o_rem   (h_rem)
    );

    arht_ram #(.DEPTH(TABLE_DEPTH), .DATA_W(arht_pkg::KEY_W), .ADDR_W(IW)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (r_idx),
        .i_wdata (k_wdata),
        .i_raddr (n_idx),
        .o_rdata (k_rdata)
    );

    arht_ram #(.DEPTH(TABLE_DEPTH), .DATA_W(arht_pkg::KEY_W), .ADDR_W(IW)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (r_idx),
        .i_wdata (r_item.new_addr),
        .i_raddr (n_idx),
        .o_rdata (v_rdata)
    );

    assign probe_key   = r_phase ? r_item.pointer_value : r_item.old_addr;
    assign hit         = (k_rdata == probe_key);
    assign empty       = (k_rdata == '0);
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_defer     = r_defer;
        h_start     = 1'b0;
        h_key       = r_item.pointer_value;
        k_we        = 1'b0;
        k_wdata     = '0;
        v_we        = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                k_we = 1'b1;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_req.valid) begin
                    n_item                = i_req.data;
                    n_res                 = '0;
                    n_res.status          = arht_pkg::ST_NOT_FOUND;
                    n_res.pointer_action  = arht_pkg::ACT_NONE;
                    n_phase               = 1'b0;
                    priority if (i_req.data.old_addr == '0) begin
                        n_state = S_DONE;
                    end else if (i_req.data.op == arht_pkg::OP_REMOVE) begin
                        n_idx   = '0;
                        n_state = S_REMOVE;
                    end else begin
                        h_start = 1'b1;
                        h_key   = i_req.data.old_addr;
                        n_state = S_HASH;
                    end
                end
            end

            S_HASH: begin
                if (h_done) begin
                    n_idx   = h_rem;
                    n_cnt   = '0;
                    n_state = S_PROBE;
                end
            end

            S_PROBE: begin
                priority if (!hit && !empty) begin
                    if (r_cnt == LAST) begin
                        // every entry taken by other keys
                        n_res.status         = arht_pkg::ST_FULL;
                        n_res.pointer_action = arht_pkg::ACT_NONE;
                        n_state              = S_DONE;
                    end else begin
                        n_idx = (r_idx == LAST) ? '0 : r_idx + 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                end else if (r_phase) begin
                    // pointer target probe
                    if (hit) begin
                        n_res.pointer_action = arht_pkg::ACT_TRANSLATE;
                        n_res.result_addr    = v_rdata;
                    end else begin
                        n_res.pointer_action = arht_pkg::ACT_DEFER;
                        n_res.target_index   = arht_pkg::t_eidx'(r_idx);
                        n_res.fixup_kind     = r_item.pointer_kind;
                        n_res.fixup_size     = r_item.item_size;
                        if (r_defer != arht_pkg::DEFER_MAX) begin
                            n_defer = r_defer + 1'b1;
                        end
                    end
                    n_state = S_DONE;
                end else if (r_item.op == arht_pkg::OP_LOOKUP) begin
                    if (hit) begin
                        n_res.status      = arht_pkg::ST_OK;
                        n_res.result_addr = v_rdata;
                        n_res.entry_index = arht_pkg::t_eidx'(r_idx);
                    end
                    n_state = S_DONE;
                end else if (hit) begin
                    n_res.status      = arht_pkg::ST_MAPPED;
                    n_res.entry_index = arht_pkg::t_eidx'(r_idx);
                    if (r_item.op == arht_pkg::OP_MAP_PTR) begin
                        n_res.pointer_action = arht_pkg::ACT_NULL;
                    end
                    n_state = S_DONE;
                end else begin
                    // insert into the empty slot
                    k_we              = 1'b1;
                    k_wdata           = r_item.old_addr;
                    v_we              = 1'b1;
                    n_res.status      = arht_pkg::ST_OK;
                    n_res.entry_index = arht_pkg::t_eidx'(r_idx);
                    priority if (r_item.op != arht_pkg::OP_MAP_PTR) begin
                        n_state = S_DONE;
                    end else if (r_item.pointer_value == '0) begin
                        n_res.pointer_action = arht_pkg::ACT_NULL;
                        n_state              = S_DONE;
                    end else begin
                        // the hash result is registered after the write lands, so the probe sees it
                        h_start = 1'b1;
                        h_key   = r_item.pointer_value;
                        n_phase = 1'b1;
                        n_state = S_HASH;
                    end
                end
            end

            S_REMOVE: begin
                if (k_rdata == r_item.old_addr) begin
                    k_we = 1'b1;
                    if (r_res.removed_count != arht_pkg::RCNT_MAX) begin
                        n_res.removed_count = r_res.removed_count + 1'b1;
                    end
                end
                if (r_idx == LAST) begin
                    n_res.status = (n_res.removed_count != '0) ? arht_pkg::ST_OK
                                                               : arht_pkg::ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out                = r_res;
                    n_out.deferred_total = r_defer;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_defer     <= '0;
            r_phase     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_defer     <= n_defer;
            r_phase     <= n_phase;
        end
        r_cnt  <= n_cnt;
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

/* src/arht_chk.sv */
// ----------------------------------------------------------------------------
// arht_chk
// Port-level checks for the address remap hash table, bound to the top.
// ----------------------------------------------------------------------------
module arht_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  arht_pkg::t_rsp i_rsp_data
);

    logic             req_xfer, rsp_xfer;
    logic [1:0]       r_inflight;
    arht_pkg::t_defer r_last_total;

    assign req_xfer = i_req_valid && i_req_ready;
    assign rsp_xfer = i_rsp_valid && i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight   <= '0;
            r_last_total <= '0;
        end else begin
            r_inflight <= r_inflight + {1'b0, req_xfer} - {1'b0, rsp_xfer};
            if (rsp_xfer) begin
                r_last_total <= i_rsp_data.deferred_total;
            end
        end
    end

    // one request in work plus one result waiting, never more
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight != 2'd3)
        else $error("more than two requests outstanding");

    a_no_orphan_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_inflight != 2'd0)
        else $error("response without outstanding request");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled response changed");

    a_defer_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_xfer |-> i_rsp_data.deferred_total >= r_last_total)
        else $error("deferred total went backward");

    a_defer_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.pointer_action == arht_pkg::ACT_DEFER
        |-> i_rsp_data.status == arht_pkg::ST_OK && i_rsp_data.removed_count == '0)
        else $error("deferred fixup with bad status");

endmodule

bind address_remap_hash_table arht_chk u_arht_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
